@@ design/tdpg_pkg.sv @@
// tdpg_pkg: shared types and constants of the trial division prime generator
// used by tdpg_cell, tdpg_chain, the top level and the bench, depends on nothing

package tdpg_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int PRIME_WIDTH_DEF = 16;

  // fixed field widths of the ports
  localparam int VALUE_W  = 16;
  localparam int INDEX_W  = 10;
  localparam int THRESH_W = 16;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd7072;

  typedef enum logic {
    ST_IDLE,
    ST_TEST
  } tdpg_state_t;

  // control that travels with a divisor down the chain
  typedef struct packed {
    logic valid;
    logic big;    // p*p exceeds the candidate
  } tdpg_tag_t;

endpackage

@@ design/tdpg_ram.sv @@
// tdpg_ram: generic single write port, single read port ram, registered read
// depends on nothing

module tdpg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/tdpg_cell.sv @@
// tdpg_cell: one restoring remainder step, shifts in one candidate bit
// depends on tdpg_pkg

module tdpg_cell
  import tdpg_pkg::*;
#(
  parameter int PW = PRIME_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          kill,
  input  logic          c_bit,
  input  tdpg_tag_t     tag_in,
  input  logic [PW-1:0] p_in,
  input  logic [PW-1:0] r_in,
  output tdpg_tag_t     tag_out,
  output logic [PW-1:0] p_out,
  output logic [PW-1:0] r_out
);

  logic [PW:0] shifted;
  logic [PW:0] reduced;

  always_comb begin
    shifted = {r_in, c_bit};
    if (shifted >= {1'b0, p_in}) begin
      reduced = shifted - {1'b0, p_in};
    end else begin
      reduced = shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || kill) begin
      tag_out.valid <= 1'b0;
    end else begin
      tag_out.valid <= tag_in.valid;
    end
    tag_out.big <= tag_in.big;
    p_out       <= p_in;
    r_out       <= reduced[PW-1:0];
  end

endmodule

@@ design/tdpg_chain.sv @@
// tdpg_chain: row of remainder cells, candidate mod divisor out of the last cell
// depends on tdpg_pkg and tdpg_cell

module tdpg_chain
  import tdpg_pkg::*;
#(
  parameter int PW = PRIME_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          kill,
  input  logic [PW-1:0] cand,
  input  tdpg_tag_t     tag_in,
  input  logic [PW-1:0] p_in,
  output tdpg_tag_t     tag_out,
  output logic [PW-1:0] rem_out
);

  tdpg_tag_t     tag_w [PW+1];
  logic [PW-1:0] p_w   [PW+1];
  logic [PW-1:0] r_w   [PW+1];

  assign tag_w[0] = tag_in;
  assign p_w[0]   = p_in;
  assign r_w[0]   = '0;

  // cell k takes candidate bits msb first
  for (genvar k = 0; k < PW; k++) begin : g_cell
    tdpg_cell #(.PW(PW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .kill    (kill),
      .c_bit   (cand[PW-1-k]),
      .tag_in  (tag_w[k]),
      .p_in    (p_w[k]),
      .r_in    (r_w[k]),
      .tag_out (tag_w[k+1]),
      .p_out   (p_w[k+1]),
      .r_out   (r_w[k+1])
    );
  end

  assign tag_out = tag_w[PW];
  assign rem_out = (p_w[PW] != '0) ? r_w[PW] : '0;

endmodule

@@ design/trial_division_prime_generator.sv @@
// trial_division_prime_generator: top level, request sequencer, prime table
// depends on tdpg_pkg, tdpg_ram, tdpg_chain
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   in_restart
//   out_     output     out_valid / out_stall out_prime_value, out_prime_index,
//                                             out_final_prime, out_exhausted
//   cfg_     input      cfg_valid / cfg_ready cfg_stop_threshold
//
// the first two primes and most exhausted answers come from the idle state;
// a candidate is tried against the stored primes in table order, each through
// the table read, the squaring stage and the remainder cell row, repeated per
// composite candidate. one request is in work at a time; the result register
// frees the input side once the result is taken or in the cycle it is taken.
// synchronous active low reset; the table is not cleared, only its count.

module trial_division_prime_generator
  import tdpg_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int PRIME_WIDTH = PRIME_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_restart,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [VALUE_W-1:0]  out_prime_value,
  output logic [INDEX_W-1:0]  out_prime_index,
  output logic                out_final_prime,
  output logic                out_exhausted,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [THRESH_W-1:0] cfg_stop_threshold
);

  localparam int PW  = PRIME_WIDTH;
  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int CNW = AW + 1;
  localparam int CW  = (PW > THRESH_W) ? PW : THRESH_W;
  localparam int IXW = (CNW > INDEX_W) ? CNW : INDEX_W;
  localparam int OW  = $clog2(PW + 4) + 1;
  localparam logic [CNW-1:0] DEPTH_C = CNW'(TABLE_DEPTH);

  tdpg_state_t    state_r, state_nxt;
  logic [CNW-1:0] count_r, count_nxt;
  logic [PW:0]    nc_r, nc_nxt;
  logic           done_r, done_nxt;
  logic [PW-1:0]  cand_r, cand_nxt;
  logic [CNW-1:0] j_r, j_nxt;
  logic           rd_valid_r;
  logic           s1_valid_r;
  logic [PW-1:0]  s1_p_r;
  logic [2*PW-1:0] s1_sq_r;
  logic [OW-1:0]  outst_r;
  logic [THRESH_W-1:0] thr_r;

  logic                out_valid_r;
  logic [VALUE_W-1:0]  out_value_r;
  logic [INDEX_W-1:0]  out_index_r;
  logic                out_final_r;
  logic                out_exh_r;

  logic           out_take, out_free, in_take;
  logic [CNW-1:0] cur_count;
  logic           cur_done;
  logic [PW:0]    cur_nc;
  logic [PW:0]    cand_step;
  logic           hit_prime, hit_comp, run_out, decide, issue, kill;
  logic           emit_en, exh_en, emit_fin;
  logic [PW-1:0]  emit_p;
  logic [CNW-1:0] emit_idx;
  logic [CW-1:0]  emit_p_ext;
  logic [IXW-1:0] emit_idx_ext;

  logic [PW-1:0]  rd_data;
  tdpg_tag_t      ch_tag_in, ch_tag_out;
  logic [PW-1:0]  ch_rem;

  assign cfg_ready = 1'b1;

  assign out_take = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || out_take;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign in_take  = in_valid && !in_stall;

  assign cur_count = in_restart ? '0 : count_r;
  assign cur_done  = in_restart ? 1'b0 : done_r;
  assign cur_nc    = in_restart ? (PW+1)'(5) : nc_r;
  assign cand_step = {1'b0, cand_r} + (PW+1)'(2);

  // first decisive divisor in table order ends the candidate
  assign hit_prime = ch_tag_out.valid && ch_tag_out.big;
  assign hit_comp  = ch_tag_out.valid && !ch_tag_out.big && (ch_rem == '0);
  assign run_out   = (outst_r == '0) && (j_r == count_r);
  assign decide    = (state_r == ST_TEST) && (hit_prime || hit_comp || run_out);
  assign issue     = (state_r == ST_TEST) && !decide && (j_r < count_r);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    nc_nxt    = nc_r;
    done_nxt  = done_r;
    cand_nxt  = cand_r;
    j_nxt     = j_r;
    emit_en   = 1'b0;
    exh_en    = 1'b0;
    emit_p    = '0;
    kill      = 1'b0;
    emit_idx  = '0;
    emit_fin  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          count_nxt = cur_count;
          done_nxt  = cur_done;
          nc_nxt    = cur_nc;
          priority if (cur_done || (cur_count >= DEPTH_C)) begin
            exh_en   = 1'b1;
            done_nxt = 1'b1;
          end else if (cur_count == '0) begin
            emit_en = 1'b1;
            emit_p  = PW'(2);
          end else if (cur_count == CNW'(1)) begin
            emit_en = 1'b1;
            emit_p  = PW'(3);
          end else if (cur_nc[PW]) begin
            exh_en   = 1'b1;
            done_nxt = 1'b1;
          end else begin
            cand_nxt  = cur_nc[PW-1:0];
            j_nxt     = '0;
            state_nxt = ST_TEST;
          end
        end
      end
      ST_TEST: begin
        if (decide) begin
          kill = 1'b1;
          if (!hit_comp) begin
            emit_en   = 1'b1;
            emit_p    = cand_r;
            nc_nxt    = cand_step;
            state_nxt = ST_IDLE;
          end else if (cand_step[PW]) begin
            // no room left in the value range
            exh_en    = 1'b1;
            done_nxt  = 1'b1;
            nc_nxt    = cand_step;
            state_nxt = ST_IDLE;
          end else begin
            cand_nxt = cand_step[PW-1:0];
            j_nxt    = '0;
          end
        end else if (issue) begin
          j_nxt = j_r + CNW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (emit_en) begin
      emit_idx  = count_nxt;
      count_nxt = count_nxt + CNW'(1);
      emit_fin  = (CW'(emit_p) >= CW'(thr_r)) || (count_nxt >= DEPTH_C);
      if (emit_fin) begin
        done_nxt = 1'b1;
      end
    end
  end

  assign emit_p_ext   = CW'(emit_p);
  assign emit_idx_ext = IXW'(emit_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      nc_r        <= (PW+1)'(5);
      done_r      <= 1'b0;
      rd_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      outst_r     <= '0;
      thr_r       <= THRESH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      nc_r       <= nc_nxt;
      done_r     <= done_nxt;
      rd_valid_r <= issue;
      s1_valid_r <= rd_valid_r && !kill;
      if (kill) begin
        outst_r <= '0;
      end else begin
        outst_r <= outst_r + OW'(issue) - OW'(ch_tag_out.valid);
      end
      if (cfg_valid) begin
        thr_r <= cfg_stop_threshold;
      end
      if (emit_en || exh_en) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cand_r  <= cand_nxt;
    j_r     <= j_nxt;
    s1_p_r  <= rd_data;
    s1_sq_r <= rd_data * rd_data;
    if (emit_en) begin
      out_value_r <= emit_p_ext[VALUE_W-1:0];
      out_index_r <= emit_idx_ext[INDEX_W-1:0];
      out_final_r <= emit_fin;
      out_exh_r   <= 1'b0;
    end else if (exh_en) begin
      out_value_r <= '0;
      out_index_r <= '0;
      out_final_r <= 1'b0;
      out_exh_r   <= 1'b1;
    end
  end

  tdpg_ram #(.WIDTH(PW), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (emit_en),
    .waddr (emit_idx[AW-1:0]),
    .wdata (emit_p),
    .raddr (j_r[AW-1:0]),
    .rdata (rd_data)
  );

  assign ch_tag_in.valid = s1_valid_r;
  assign ch_tag_in.big   = s1_sq_r > {{PW{1'b0}}, cand_r};

  tdpg_chain #(.PW(PW)) u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .kill    (kill),
    .cand    (cand_r),
    .tag_in  (ch_tag_in),
    .p_in    (s1_p_r),
    .tag_out (ch_tag_out),
    .rem_out (ch_rem)
  );

  assign out_valid       = out_valid_r;
  assign out_prime_value = out_value_r;
  assign out_prime_index = out_index_r;
  assign out_final_prime = out_final_r;
  assign out_exhausted   = out_exh_r;

endmodule

@@ bench/tb_top.sv @@
// tb_top: self-checking bench for trial_division_prime_generator
// tracks the prime sequence, table fill and threshold in a scoreboard class
// depends on tdpg_pkg and the design top level

module tb_top
  import tdpg_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PRIME   = (1 << PRIME_WIDTH_DEF) - 1;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int          SETTLE_CYCLES = 64;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
    logic               is_final;
    logic               exhausted;
  } prime_result_t;

  class prime_sequence_checker;
    int unsigned   found_primes [TABLE_DEPTH_DEF];
    int unsigned   found_count;
    int unsigned   next_odd;
    bit            gen_ended;
    int unsigned   threshold;
    prime_result_t expected_primes [$];
    int unsigned   error_count;

    function new();
      threshold   = THRESH_RESET;
      error_count = 0;
      clear_sequence();
    endfunction

    function void clear_sequence();
      found_count = 0;
      next_odd    = 5;
      gen_ended   = 1'b0;
    endfunction

    function void set_threshold(logic [THRESH_W-1:0] v);
      threshold = v;
    endfunction

    function int unsigned pending();
      return expected_primes.size();
    endfunction

    // only primes with p*p <= c are tried
    function bit has_divisor(int unsigned c);
      longint unsigned p;
      for (int j = 0; j < found_count; j++) begin
        p = found_primes[j];
        if (p * p > c) break;
        if (c % p == 0) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void append_prime(int unsigned p);
      prime_result_t r;
      r.index = INDEX_W'(found_count);
      found_primes[found_count] = p;
      found_count++;
      r.value     = VALUE_W'(p);
      r.is_final  = (p >= threshold) || (found_count >= TABLE_DEPTH_DEF);
      r.exhausted = 1'b0;
      if (r.is_final) gen_ended = 1'b1;
      expected_primes.push_back(r);
    endfunction

    function void push_exhausted();
      prime_result_t r;
      r = '0;
      r.exhausted = 1'b1;
      gen_ended = 1'b1;
      expected_primes.push_back(r);
    endfunction

    function void note_request(bit restart);
      int unsigned c;
      if (restart) clear_sequence();
      if (gen_ended || found_count >= TABLE_DEPTH_DEF) begin
        push_exhausted();
        return;
      end
      if (found_count == 0) begin
        append_prime(2);
        return;
      end
      if (found_count == 1) begin
        append_prime(3);
        return;
      end
      for (c = next_odd; c <= MAX_PRIME; c += 2) begin
        if (!has_divisor(c)) begin
          next_odd = c + 2;
          append_prime(c);
          return;
        end
      end
      // ran past the value range
      next_odd = c;
      push_exhausted();
    endfunction

    function void check_result(prime_result_t got);
      prime_result_t want;
      if (expected_primes.size() == 0) begin
        $error("unexpected result: prime_value %0d prime_index %0d", got.value, got.index);
        error_count++;
        return;
      end
      want = expected_primes.pop_front();
      if (got.value !== want.value) begin
        $error("prime_value expected %0d actual %0d", want.value, got.value);
        error_count++;
      end
      if (got.index !== want.index) begin
        $error("prime_index expected %0d actual %0d", want.index, got.index);
        error_count++;
      end
      if (got.is_final !== want.is_final) begin
        $error("final_prime expected %0d actual %0d", want.is_final, got.is_final);
        error_count++;
      end
      if (got.exhausted !== want.exhausted) begin
        $error("exhausted expected %0d actual %0d", want.exhausted, got.exhausted);
        error_count++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_restart = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [VALUE_W-1:0]  out_prime_value;
  logic [INDEX_W-1:0]  out_prime_index;
  logic                out_final_prime;
  logic                out_exhausted;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [THRESH_W-1:0] cfg_stop_threshold = '0;

  prime_sequence_checker sb;
  int                    send_idle_pct = 0;
  int                    stall_pct = 0;
  int unsigned           cycle_count = 0;

  trial_division_prime_generator u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_restart         (in_restart),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_prime_value    (out_prime_value),
    .out_prime_index    (out_prime_index),
    .out_final_prime    (out_final_prime),
    .out_exhausted      (out_exhausted),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_stop_threshold (cfg_stop_threshold)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_threshold(cfg_stop_threshold);
      if (in_valid && !in_stall) sb.note_request(in_restart);
      if (out_valid && !out_stall)
        sb.check_result(prime_result_t'({out_prime_value, out_prime_index,
                                         out_final_prime, out_exhausted}));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL trial_division_prime_generator");
      $finish;
    end
  end

  // valid stays high after acceptance; the caller lowers it or sends again
  task automatic send_request(bit restart);
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic sender_gap();
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid   <= 1'b0;
      in_restart <= 1'($urandom);
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_threshold(logic [THRESH_W-1:0] v);
    cfg_valid          <= 1'b1;
    cfg_stop_threshold <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic [THRESH_W-1:0] thr, int send_pct, int recv_pct,
                           int n_items, int restart_pct);
    bit restart;
    drain();
    write_threshold(thr);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    for (int i = 0; i < n_items; i++) begin
      restart = (i == 0) || ($urandom_range(0, 99) < restart_pct);
      send_request(restart);
      // wait for the block to empty once per phase
      if (i == n_items / 2) drain();
      else sender_gap();
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // fresh start without restart
    repeat (4) send_request(1'b0);

    // lowest threshold: every first prime is final
    drain();
    write_threshold(16'd2);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);

    drain();
    write_threshold(16'd3);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);

    // threshold equal to a prime
    drain();
    write_threshold(16'd5);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);

    drain();
    write_threshold(16'd4);
    send_request(1'b1);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);

    // highest threshold: a long climb through the prime table
    run_phase(16'hFFFF, 0, 0, 480, 0);
    run_phase(THRESH_W'($urandom_range(2, 65535)), 48, 0, 100, 4);
    run_phase(THRESH_W'($urandom_range(2, 400)), 0, 48, 100, 4);
    run_phase(THRESH_W'($urandom_range(2, 200)), 28, 28, 100, 4);
    run_phase(THRESH_W'($urandom_range(2, 1000)), 0, 0, 100, 10);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("PASS trial_division_prime_generator");
    end else begin
      $display("FAIL trial_division_prime_generator");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/tdpg_pkg.sv
design/tdpg_ram.sv
design/tdpg_cell.sv
design/tdpg_chain.sv
design/trial_division_prime_generator.sv
bench/tb_top.sv
